FILE: rtl/core/svm_pkg.sv
package svm_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned REG_COUNT_DEF   = 16;
  localparam int unsigned STEP_LIMIT_DEF  = 10000000;
  localparam int unsigned STEP_W          = 24;
  localparam logic [63:0] MIX_GOLDEN      = 64'h9E37_79B9_7F4A_7C15;

  typedef enum logic [4:0] {
    OP_PUSH_CONST = 5'd0,
    OP_PUSH_GPR   = 5'd1,
    OP_POP        = 5'd2,
    OP_ADD        = 5'd3,
    OP_SUB        = 5'd4,
    OP_MUL        = 5'd5,
    OP_XOR        = 5'd6,
    OP_MOV        = 5'd7,
    OP_JMP        = 5'd8,
    OP_JZ         = 5'd9,
    OP_JNZ        = 5'd10,
    OP_CALL       = 5'd11,
    OP_RET        = 5'd12,
    OP_NOP        = 5'd13,
    OP_SCRAMBLE   = 5'd14,
    OP_UNSCRAMBLE = 5'd15,
    OP_AND        = 5'd16,
    OP_OR         = 5'd17,
    OP_SHL        = 5'd18,
    OP_SHR        = 5'd19,
    OP_NOT        = 5'd20,
    OP_NEG        = 5'd21,
    OP_CMP        = 5'd22,
    OP_LOAD       = 5'd23,
    OP_MEM_WRITE  = 5'd24,
    OP_HALT       = 5'd25,
    OP_UNKNOWN    = 5'd26,
    OP_LOAD_DATA  = 5'd27
  } op_e;

  typedef enum logic [2:0] {
    CAUSE_NONE       = 3'd0,
    CAUSE_HALT       = 3'd1,
    CAUSE_UNKNOWN    = 3'd2,
    CAUSE_CODE_END   = 3'd3,
    CAUSE_STEP_LIMIT = 3'd4
  } stop_e;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ALU_MUL        = 2'd0,
    ALU_SCRAMBLE   = 2'd1,
    ALU_UNSCRAMBLE = 2'd2
  } alu_kind_e;

  typedef struct packed {
    logic      start;
    alu_kind_e kind;
  } alu_cmd_t;

endpackage

FILE: rtl/core/svm_if.sv
interface svm_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  operation;
  logic [7:0]  reg_first;
  logic [7:0]  reg_second;
  logic [63:0] immediate;
  logic [31:0] jump_target;
  logic [63:0] memory_data;

  modport source (output valid, operation, reg_first, reg_second, immediate,
                  jump_target, memory_data, input ready);
  modport sink   (input valid, operation, reg_first, reg_second, immediate,
                  jump_target, memory_data, output ready);
endinterface

interface svm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        is_running;
  logic [2:0]  stop_cause;
  logic [1:0]  memory_request;
  logic [63:0] memory_address;
  logic [63:0] memory_write_data;
  logic [8:0]  stack_depth;

  modport source (output valid, next_pc, is_running, stop_cause, memory_request,
                  memory_address, memory_write_data, stack_depth, input ready);
  modport sink   (input valid, next_pc, is_running, stop_cause, memory_request,
                  memory_address, memory_write_data, stack_depth, output ready);
endinterface

FILE: rtl/core/svm_stack_mem.sv
module svm_stack_mem
  import svm_pkg::*;
#(
  parameter int unsigned DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_a_i,
  input  logic [AW-1:0] rd_addr_b_i,
  output logic [63:0]   rd_data_a_o,
  output logic [63:0]   rd_data_b_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_a_q;
  logic [63:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

FILE: rtl/core/svm_reg_file.sv
module svm_reg_file
  import svm_pkg::*;
#(
  parameter int unsigned COUNT = REG_COUNT_DEF,
  localparam int unsigned RW = $clog2(COUNT)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [RW-1:0] rd_addr_a_i,
  input  logic [RW-1:0] rd_addr_b_i,
  output logic [63:0]   rd_data_a_o,
  output logic [63:0]   rd_data_b_o,
  input  logic          wr_en_i,
  input  logic [RW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i
);

  logic [63:0]      mem [COUNT];
  logic [COUNT-1:0] written_q;
  logic [63:0]      rd_a_q;
  logic [63:0]      rd_b_q;
  logic             vld_a_q;
  logic             vld_b_q;

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_a_q <= written_q[rd_addr_a_i];
        vld_b_q <= written_q[rd_addr_b_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = vld_a_q ? rd_a_q : 64'd0;
  assign rd_data_b_o = vld_b_q ? rd_b_q : 64'd0;

endmodule

FILE: rtl/core/svm_alu_seq.sv
module svm_alu_seq
  import svm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  alu_cmd_t    cmd_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] result_o
);

  logic        busy_q;
  logic        done_q;
  logic [2:0]  cnt_q;
  alu_kind_e   kind_q;
  logic [63:0] v_q;
  logic [63:0] k_q;
  logic [63:0] t_q;
  logic [63:0] acc_q;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] k_rot;
  logic [63:0] mixed;
  logic        last;

  // Multiply: low partial product, then the two cross terms into the top half.
  always_comb begin
    mul_a = (cnt_q == 3'd2) ? v_q[63:32] : v_q[31:0];
    mul_b = (cnt_q == 3'd1) ? k_q[63:32] : k_q[31:0];
    prod  = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // Scramble round split in two steps: mix sum, then fold back into the value.
  always_comb begin
    k_rot = (kind_q == ALU_UNSCRAMBLE) ? {k_q[6:0], k_q[63:7]} : k_q;
    mixed = v_q ^ t_q;
  end

  assign last = (kind_q == ALU_MUL) ? (cnt_q == 3'd2) : (cnt_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      kind_q <= ALU_MUL;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      kind_q <= cmd_i.kind;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (last) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      v_q <= a_i;
      k_q <= b_i;
    end else if (busy_q) begin
      if (kind_q == ALU_MUL) begin
        if (cnt_q == 3'd0) begin
          acc_q <= prod;
        end else begin
          acc_q[63:32] <= acc_q[63:32] + prod[31:0];
        end
      end else if (!cnt_q[0]) begin
        t_q <= k_rot + MIX_GOLDEN + (v_q << 6) + (v_q >> 2);
        k_q <= k_rot;
      end else begin
        v_q <= v_q ^ (k_q + {mixed[50:0], mixed[63:51]});
        if (kind_q == ALU_SCRAMBLE) begin
          k_q <= {k_q[56:0], k_q[63:57]};
        end
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = (kind_q == ALU_MUL) ? acc_q : v_q;

endmodule

FILE: rtl/core/stack_vm_execute.sv
// Executes one decoded 64-bit stack machine instruction per input word and
// returns one result word for each. The accept edge reads the top two stack
// entries and both operand registers from their synchronous memories; a
// later edge writes back and loads the result register.
// Multiply holds the word longer (three 32x32 partial products through one
// multiplier, then a hand-over of the product) and scramble or unscramble
// too (two steps per round over four rounds, then the hand-over). A new word
// is taken once the previous one has written back.
// The result register lets the next word in while a result waits to be taken;
// that word then holds its write-back until the result register is free.
// The stack memory needs no clearing after reset; the register file reads as
// zero until written. code_size may only be written while the block is idle.
module stack_vm_execute
  import svm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned REG_COUNT   = REG_COUNT_DEF,
  parameter int unsigned STEP_LIMIT  = STEP_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  svm_in_if.sink      in_i,
  svm_out_if.source   out_o
);

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RW  = $clog2(REG_COUNT);
  localparam logic [SPW-1:0]    SP_FULL  = SPW'(STACK_DEPTH);
  localparam logic [7:0]        REG_LIM  = 8'(REG_COUNT);
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(STEP_LIMIT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ITER
  } state_e;

  state_e state_q;

  // Architectural state
  logic [31:0]       code_size_q;
  logic [31:0]       pc_q, pc_d;
  logic [SPW-1:0]    sp_q, sp_d;
  logic              run_q, run_d;
  stop_e             cause_q, cause_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              pend_q, pend_d;
  logic [RW-1:0]     pend_reg_q, pend_reg_d;

  // Held instruction word
  logic [4:0]  op_q;
  logic [7:0]  ra_q;
  logic [7:0]  rb_q;
  logic [63:0] imm_q;
  logic [31:0] tgt_q;
  logic [63:0] mdat_q;

  // Result register
  logic        out_valid_q;
  logic [31:0] o_pc_q;
  logic        o_run_q;
  stop_e       o_cause_q;
  req_e        o_req_q;
  logic [63:0] o_addr_q;
  logic [63:0] o_wdata_q;
  logic [8:0]  o_depth_q;

  logic accept, out_free, finish, long_op, exec_ok;

  logic [63:0]   top_w, below_w, rf_a, rf_b, alu_res, bin_r;
  logic          alu_done;
  alu_cmd_t      alu_cmd;
  logic [SPW-1:0] sp_m1, sp_m2;

  logic          stk_we;
  logic [AW-1:0] stk_wa;
  logic [63:0]   stk_wd;
  logic          rf_we;
  logic [RW-1:0] rf_wa;
  logic [63:0]   rf_wd;
  req_e          req;
  logic [63:0]   maddr, mwdata;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_o.ready;
  assign sp_m1    = sp_q - SPW'(1);
  assign sp_m2    = sp_q - SPW'(2);

  svm_stack_mem #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .rd_addr_a_i (sp_m1[AW-1:0]),
    .rd_addr_b_i (sp_m2[AW-1:0]),
    .rd_data_a_o (top_w),
    .rd_data_b_o (below_w),
    .wr_en_i     (stk_we),
    .wr_addr_i   (stk_wa),
    .wr_data_i   (stk_wd)
  );

  svm_reg_file #(.COUNT(REG_COUNT)) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_a_i (in_i.reg_first[RW-1:0]),
    .rd_addr_b_i (in_i.reg_second[RW-1:0]),
    .rd_data_a_o (rf_a),
    .rd_data_b_o (rf_b),
    .wr_en_i     (rf_we),
    .wr_addr_i   (rf_wa),
    .wr_data_i   (rf_wd)
  );

  svm_alu_seq u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (alu_cmd),
    .a_i      (below_w),
    .b_i      (top_w),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  // An instruction proper runs only when live and inside the code.
  assign exec_ok = (op_q < OP_UNKNOWN) && run_q && (pc_q < code_size_q);
  assign long_op = exec_ok && (sp_q >= SPW'(2)) &&
                   ((op_q == OP_MUL) || (op_q == OP_SCRAMBLE) || (op_q == OP_UNSCRAMBLE));

  always_comb begin
    alu_cmd.start = (state_q == S_EXEC) && long_op;
    case (op_e'(op_q))
      OP_SCRAMBLE:   alu_cmd.kind = ALU_SCRAMBLE;
      OP_UNSCRAMBLE: alu_cmd.kind = ALU_UNSCRAMBLE;
      default:       alu_cmd.kind = ALU_MUL;
    endcase
  end

  assign finish = out_free &&
                  (((state_q == S_EXEC) && !long_op) || ((state_q == S_ITER) && alu_done));

  // Combinational binary results; the long ones come from the sequential unit.
  always_comb begin
    case (op_e'(op_q))
      OP_ADD:  bin_r = below_w + top_w;
      OP_SUB:  bin_r = below_w - top_w;
      OP_XOR:  bin_r = below_w ^ top_w;
      OP_AND:  bin_r = below_w & top_w;
      OP_OR:   bin_r = below_w | top_w;
      OP_SHL:  bin_r = below_w << top_w[5:0];
      OP_SHR:  bin_r = below_w >> top_w[5:0];
      OP_CMP:  bin_r = (below_w == top_w) ? 64'd0 :
                       (below_w > top_w) ? 64'd1 : '1;
      default: bin_r = alu_res;
    endcase
  end

  // Write-back: next architectural state and memory writes for this word.
  always_comb begin
    logic ra_ok, rb_ok, sp_ne, sp_full, sp_ge2;
    logic [31:0] pc_n;
    ra_ok   = ra_q < REG_LIM;
    rb_ok   = rb_q < REG_LIM;
    sp_ne   = sp_q != '0;
    sp_full = sp_q == SP_FULL;
    sp_ge2  = sp_q >= SPW'(2);
    pc_n    = pc_q + 32'd1;

    pc_d = pc_q; sp_d = sp_q; run_d = run_q; cause_d = cause_q;
    step_d = step_q; pend_d = pend_q; pend_reg_d = pend_reg_q;
    stk_we = 1'b0; stk_wa = sp_q[AW-1:0]; stk_wd = imm_q;
    rf_we = 1'b0; rf_wa = ra_q[RW-1:0]; rf_wd = top_w;
    req = REQ_NONE; maddr = '0; mwdata = '0;

    if (op_q == OP_LOAD_DATA) begin
      // Complete a pending load, even when stopped.
      if (pend_q) begin
        rf_we  = 1'b1;
        rf_wa  = pend_reg_q;
        rf_wd  = mdat_q;
        pend_d = 1'b0;
      end
    end else if (!run_q) begin
      // Stopped: hold everything.
    end else if (pc_q >= code_size_q) begin
      run_d   = 1'b0;
      cause_d = CAUSE_CODE_END;
    end else if (op_q >= OP_UNKNOWN) begin
      pc_d    = pc_n;
      run_d   = 1'b0;
      cause_d = CAUSE_UNKNOWN;
    end else begin
      case (op_e'(op_q))
        OP_PUSH_CONST: begin
          pc_d = pc_n + 32'd8;
          if (!sp_full) begin
            stk_we = 1'b1;
            sp_d   = sp_q + SPW'(1);
          end
        end
        OP_PUSH_GPR: begin
          pc_d   = pc_n + 32'd1;
          stk_wd = rf_a;
          if (!sp_full && ra_ok) begin
            stk_we = 1'b1;
            sp_d   = sp_q + SPW'(1);
          end
        end
        OP_POP: begin
          pc_d = pc_n + 32'd1;
          if (sp_ne && ra_ok) begin
            rf_we = 1'b1;
            sp_d  = sp_m1;
          end
        end
        OP_MOV: begin
          pc_d  = pc_n + 32'd2;
          rf_wd = rf_b;
          rf_we = ra_ok && rb_ok;
        end
        OP_JMP: pc_d = tgt_q;
        OP_JZ, OP_JNZ: begin
          pc_d = pc_n + 32'd4;
          if (sp_ne && ((top_w == 64'd0) == (op_q == OP_JZ))) begin
            pc_d = tgt_q;
          end
        end
        OP_CALL: begin
          pc_d   = tgt_q;
          stk_wd = {32'd0, pc_n + 32'd4};
          if (!sp_full) begin
            stk_we = 1'b1;
            sp_d   = sp_q + SPW'(1);
          end
        end
        OP_RET: begin
          pc_d = pc_n;
          if (sp_ne) begin
            pc_d = top_w[31:0];
            sp_d = sp_m1;
          end
        end
        OP_NOT, OP_NEG: begin
          pc_d   = pc_n;
          stk_wa = sp_m1[AW-1:0];
          stk_wd = (op_q == OP_NOT) ? ~top_w : (64'd0 - top_w);
          stk_we = sp_ne;
        end
        OP_LOAD, OP_MEM_WRITE: begin
          pc_d = pc_n + 32'd1;
          if (sp_ne && ra_ok) begin
            sp_d  = sp_m1;
            maddr = top_w;
            if (op_q == OP_LOAD) begin
              req        = REQ_READ;
              pend_d     = 1'b1;
              pend_reg_d = ra_q[RW-1:0];
            end else begin
              req    = REQ_WRITE;
              mwdata = rf_a;
            end
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_XOR, OP_SCRAMBLE, OP_UNSCRAMBLE,
        OP_AND, OP_OR, OP_SHL, OP_SHR, OP_CMP: begin
          pc_d   = pc_n;
          stk_wa = sp_m2[AW-1:0];
          stk_wd = bin_r;
          if (sp_ge2) begin
            stk_we = 1'b1;
            sp_d   = sp_m1;
          end
        end
        default: pc_d = pc_n;   // nop, halt
      endcase
      if (op_q == OP_HALT) begin
        run_d   = 1'b0;
        cause_d = CAUSE_HALT;
      end
      if (step_q >= STEP_MAX) begin
        if (op_q != OP_HALT) begin
          run_d   = 1'b0;
          cause_d = CAUSE_STEP_LIMIT;
        end
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end

    // Drop every write unless the word actually retires this cycle.
    stk_we = stk_we && finish;
    rf_we  = rf_we && finish;
  end

  // Sequencer, architectural registers and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      code_size_q <= '0;
      pc_q        <= '0;
      sp_q        <= '0;
      run_q       <= 1'b1;
      cause_q     <= CAUSE_NONE;
      step_q      <= '0;
      pend_q      <= 1'b0;
      pend_reg_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        code_size_q <= cfg_data_i;
      end
      if (finish) begin
        state_q     <= S_IDLE;
        pc_q        <= pc_d;
        sp_q        <= sp_d;
        run_q       <= run_d;
        cause_q     <= cause_d;
        step_q      <= step_d;
        pend_q      <= pend_d;
        pend_reg_q  <= pend_reg_d;
        out_valid_q <= 1'b1;
      end else begin
        if (out_o.ready) begin
          out_valid_q <= 1'b0;
        end
        case (state_q)
          S_IDLE: begin
            if (accept) begin
              state_q <= S_EXEC;
            end
          end
          S_EXEC: begin
            if (long_op) begin
              state_q <= S_ITER;
            end
          end
          S_ITER: ;
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  // Payload registers: instruction word and result word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_i.operation;
      ra_q   <= in_i.reg_first;
      rb_q   <= in_i.reg_second;
      imm_q  <= in_i.immediate;
      tgt_q  <= in_i.jump_target;
      mdat_q <= in_i.memory_data;
    end
    if (finish) begin
      o_pc_q    <= pc_d;
      o_run_q   <= run_d;
      o_cause_q <= cause_d;
      o_req_q   <= req;
      o_addr_q  <= maddr;
      o_wdata_q <= mwdata;
      o_depth_q <= 9'(sp_d);
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.next_pc           = o_pc_q;
  assign out_o.is_running        = o_run_q;
  assign out_o.stop_cause        = o_cause_q;
  assign out_o.memory_request    = o_req_q;
  assign out_o.memory_address    = o_addr_q;
  assign out_o.memory_write_data = o_wdata_q;
  assign out_o.stack_depth       = o_depth_q;

`ifndef SYNTHESIS
  // Stack pointer never runs past the stack.
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_FULL) else $error("stack pointer beyond depth");

  // Each retired word moves the stack pointer by at most one entry.
  a_sp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> (sp_d == sp_q || sp_d == sp_q + SPW'(1) || sp_d == sp_m1))
    else $error("stack pointer jumped");

  // A stopped machine stays stopped.
  a_run_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |=> !run_q) else $error("machine restarted");

  // A result only appears after a word has been worked on.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q != S_IDLE))
    else $error("result without work");
`endif

endmodule

FILE: tb/tb_stack_vm_execute.sv
module tb_stack_vm_execute
  import svm_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Step limit is brought down so that the run can reach it.
  localparam int unsigned STK_N    = 256;
  localparam int unsigned REGS_N   = 16;
  localparam int unsigned STEP_CAP = 1500;
  // Cycles to hold after the last result before a register write or the verdict.
  localparam int unsigned SETTLE   = 24;
  localparam int unsigned HOLD_OFF = 400;

  // One decoded instruction word as offered to the block.
  typedef struct {
    logic [4:0]  op;
    logic [7:0]  ra;
    logic [7:0]  rb;
    logic [63:0] imm;
    logic [31:0] tgt;
    logic [63:0] mdat;
  } in_word_t;

  // One result word.
  typedef struct {
    logic [31:0] next_pc;
    logic        running;
    logic [2:0]  cause;
    logic [1:0]  req;
    logic [63:0] addr;
    logic [63:0] wdata;
    logic [8:0]  depth;
  } out_word_t;

  // Architectural state of the machine as the testbench sees it.
  typedef struct {
    logic [31:0] code_size;
    logic [31:0] pc;
    int unsigned sp;
    logic [63:0] stk [STK_N];
    logic [63:0] regs [REGS_N];
    bit          running;
    int unsigned steps;
    bit          load_wait;
    int unsigned load_reg;
    logic [2:0]  cause;
  } vm_state_t;

  function automatic logic [63:0] rotl64(logic [63:0] x, int unsigned s);
    return (x << s) | (x >> (64 - s));
  endfunction

  function automatic logic [63:0] fold_mix(logic [63:0] a, logic [63:0] b);
    return a ^ (b + MIX_GOLDEN + (a << 6) + (a >> 2));
  endfunction

  // Four rounds of the scramble; backward rotates the key before each round.
  function automatic logic [63:0] churn4(logic [63:0] v, logic [63:0] k, bit backward);
    for (int r = 0; r < 4; r++) begin
      if (backward) k = rotl64(k, 57);
      v ^= k + rotl64(fold_mix(v, k), 13);
      if (!backward) k = rotl64(k, 7);
    end
    return v;
  endfunction

  function automatic void clear_machine(inout vm_state_t s);
    s.code_size = '0;
    s.pc        = '0;
    s.sp        = 0;
    foreach (s.stk[i]) s.stk[i] = '0;
    foreach (s.regs[i]) s.regs[i] = '0;
    s.running   = 1'b1;
    s.steps     = 0;
    s.load_wait = 1'b0;
    s.load_reg  = 0;
    s.cause     = CAUSE_NONE;
  endfunction

  // Execute one word on s and return the result word it yields.
  function automatic out_word_t exec_word(inout vm_state_t s, input in_word_t w);
    out_word_t   r;
    logic [31:0] pc;
    int unsigned sp;
    logic [63:0] a, b, v;
    bit          zero;
    r.req   = REQ_NONE;
    r.addr  = '0;
    r.wdata = '0;
    pc = s.pc;
    sp = s.sp;
    if (w.op == OP_LOAD_DATA) begin
      // complete a pending load even on a stopped machine
      if (s.load_wait) begin
        s.regs[s.load_reg] = w.mdat;
        s.load_wait = 1'b0;
      end
    end else if (!s.running) begin
    end else if (pc >= s.code_size) begin
      s.running = 1'b0;
      s.cause   = CAUSE_CODE_END;
    end else if (w.op >= OP_UNKNOWN) begin
      s.pc      = pc + 32'd1;
      s.running = 1'b0;
      s.cause   = CAUSE_UNKNOWN;
    end else begin
      pc = pc + 32'd1;
      case (w.op)
        OP_PUSH_CONST: begin
          pc += 32'd8;
          if (sp < STK_N) begin s.stk[sp] = w.imm; sp++; end
        end
        OP_PUSH_GPR: begin
          pc += 32'd1;
          if (sp < STK_N && w.ra < REGS_N) begin s.stk[sp] = s.regs[w.ra]; sp++; end
        end
        OP_POP: begin
          pc += 32'd1;
          if (sp > 0 && w.ra < REGS_N) begin sp--; s.regs[w.ra] = s.stk[sp]; end
        end
        OP_MOV: begin
          pc += 32'd2;
          if (w.ra < REGS_N && w.rb < REGS_N) s.regs[w.ra] = s.regs[w.rb];
        end
        OP_JMP: pc = w.tgt;
        OP_JZ, OP_JNZ: begin
          pc += 32'd4;
          if (sp > 0) begin
            zero = (s.stk[sp-1] == '0);
            if (zero == (w.op == OP_JZ)) pc = w.tgt;
          end
        end
        OP_CALL: begin
          pc += 32'd4;
          // a full stack drops the return address but still jumps
          if (sp < STK_N) begin s.stk[sp] = {32'd0, pc}; sp++; end
          pc = w.tgt;
        end
        OP_RET: begin
          if (sp > 0) begin sp--; pc = s.stk[sp][31:0]; end
        end
        OP_NOT: if (sp > 0) s.stk[sp-1] = ~s.stk[sp-1];
        OP_NEG: if (sp > 0) s.stk[sp-1] = 64'd0 - s.stk[sp-1];
        OP_LOAD, OP_MEM_WRITE: begin
          pc += 32'd1;
          if (sp > 0 && w.ra < REGS_N) begin
            sp--;
            r.addr = s.stk[sp];
            if (w.op == OP_LOAD) begin
              r.req       = REQ_READ;
              s.load_wait = 1'b1;
              s.load_reg  = w.ra;
            end else begin
              r.req   = REQ_WRITE;
              r.wdata = s.regs[w.ra];
            end
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_XOR, OP_SCRAMBLE, OP_UNSCRAMBLE,
        OP_AND, OP_OR, OP_SHL, OP_SHR, OP_CMP: begin
          if (sp >= 2) begin
            b = s.stk[sp-1];
            a = s.stk[sp-2];
            case (w.op)
              OP_ADD:        v = a + b;
              OP_SUB:        v = a - b;
              OP_MUL:        v = a * b;
              OP_XOR:        v = a ^ b;
              OP_SCRAMBLE:   v = churn4(a, b, 1'b0);
              OP_UNSCRAMBLE: v = churn4(a, b, 1'b1);
              OP_AND:        v = a & b;
              OP_OR:         v = a | b;
              OP_SHL:        v = a << b[5:0];
              OP_SHR:        v = a >> b[5:0];
              default:       v = (a == b) ? 64'd0 : ((a > b) ? 64'd1 : '1);
            endcase
            sp--;
            s.stk[sp-1] = v;
          end
        end
        default: ;
      endcase
      s.pc = pc;
      s.sp = sp;
      if (w.op == OP_HALT) begin
        s.running = 1'b0;
        s.cause   = CAUSE_HALT;
      end
      if (s.steps >= STEP_CAP) begin
        if (s.running) begin
          s.running = 1'b0;
          s.cause   = CAUSE_STEP_LIMIT;
        end
      end else begin
        s.steps++;
      end
    end
    r.next_pc = s.pc;
    r.running = s.running;
    r.cause   = s.cause;
    r.depth   = s.sp[8:0];
    return r;
  endfunction

  // Holds the machine state and the result words still owed by the block.
  class exec_scoreboard;
    vm_state_t machine;
    out_word_t results_due[$];
    int unsigned fails;

    function new();
      clear_machine(machine);
      fails = 0;
    endfunction

    function void note_word(in_word_t w);
      results_due.push_back(exec_word(machine, w));
    endfunction

    function void match(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (results_due.size() == 0) begin
        $error("result word with none expected (pc %h)", got.next_pc);
        fails++;
        return;
      end
      want = results_due.pop_front();
      match("next_pc", want.next_pc, got.next_pc);
      match("is_running", want.running, got.running);
      match("stop_cause", want.cause, got.cause);
      match("memory_request", want.req, got.req);
      match("memory_address", want.addr, got.addr);
      match("memory_write_data", want.wdata, got.wdata);
      match("stack_depth", want.depth, got.depth);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [31:0] cfg_data;

  svm_in_if  in_bus ();
  svm_out_if out_bus ();

  stack_vm_execute #(
    .STEP_LIMIT (STEP_CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  exec_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  int unsigned results_seen  = 0;
  int unsigned stall_left    = 0;
  bit          stalled_once  = 1'b0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Overall time limit, well above the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_stack_vm_execute NOT OK");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off once a few hundred
  // words have gone through, so the block fills up and stalls its input.
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!stalled_once && results_seen >= 300) begin
        stalled_once = 1'b1;
        stall_left   = HOLD_OFF - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= take_idle_pct);
      end
    end
  end

  // Check every accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    out_word_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.next_pc = out_bus.next_pc;
      got.running = out_bus.is_running;
      got.cause   = out_bus.stop_cause;
      got.req     = out_bus.memory_request;
      got.addr    = out_bus.memory_address;
      got.wdata   = out_bus.memory_write_data;
      got.depth   = out_bus.stack_depth;
      sb.check_result(got);
      results_seen++;
    end
  end

  function automatic in_word_t make_word(logic [4:0] op, logic [7:0] ra = 8'd0,
                                         logic [7:0] rb = 8'd0, logic [63:0] imm = '0,
                                         logic [31:0] tgt = '0);
    in_word_t w;
    w.op   = op;
    w.ra   = ra;
    w.rb   = rb;
    w.imm  = imm;
    w.tgt  = tgt;
    w.mdat = {$urandom, $urandom};
    return w;
  endfunction

  // Offer one word, idling at random first; note it once the block takes it.
  // Called on a rising edge; returns on the edge that accepted the word.
  task automatic send_word(in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.operation   <= w.op;
    in_bus.reg_first   <= w.ra;
    in_bus.reg_second  <= w.rb;
    in_bus.immediate   <= w.imm;
    in_bus.jump_target <= w.tgt;
    in_bus.memory_data <= w.mdat;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_word(w);
  endtask

  // Drop valid and wait until every owed result has been taken.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write code_size on an idle block; optionally jump below the new end first.
  task automatic write_code_size(logic [31:0] v, bit keep_going = 1'b1);
    if (keep_going && sb.machine.pc >= v)
      send_word(make_word(OP_JMP, 0, 0, 0, $urandom_range(0, v - 1)));
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    sb.machine.code_size = v;
  endtask

  function automatic logic [7:0] pick_reg();
    return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, REGS_N - 1))
                                        : 8'($urandom_range(0, 255));
  endfunction

  // True when the word leaves the machine running with its pc inside the code.
  function automatic bit keeps_going(in_word_t w);
    vm_state_t trial;
    out_word_t r;
    trial = sb.machine;
    r = exec_word(trial, w);
    return trial.running && (trial.pc < trial.code_size);
  endfunction

  // A random word that keeps the machine alive; push_pct biases stack growth.
  function automatic in_word_t random_word(int unsigned push_pct);
    in_word_t    w;
    int unsigned roll;
    logic [31:0] cs;
    cs = sb.machine.code_size;
    for (int tries = 0; tries < 8; tries++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) w.op = OP_LOAD_DATA;
      else if (roll < 8 + push_pct) w.op = $urandom_range(0, 3) != 0 ? OP_PUSH_CONST : OP_PUSH_GPR;
      else begin
        do w.op = 5'($urandom_range(OP_POP, OP_MEM_WRITE));
        while (w.op == OP_PUSH_GPR);
      end
      w.ra = pick_reg();
      w.rb = pick_reg();
      roll = $urandom_range(0, 99);
      if (roll < 15) w.imm = 64'($urandom_range(0, 3));
      else if (roll < 30) w.imm = 64'($urandom_range(0, cs - 1));
      else w.imm = {$urandom, $urandom};
      w.tgt  = ($urandom_range(0, 99) < 70) ? 32'($urandom_range(0, cs - 1)) : 32'($urandom);
      w.mdat = {$urandom, $urandom};
      if (keeps_going(w)) return w;
    end
    return make_word(OP_JMP, 0, 0, 0, $urandom_range(0, cs - 1));
  endfunction

  task automatic run_random(int unsigned count, int unsigned push_pct);
    repeat (count) send_word(random_word(push_pct));
  endtask

  initial begin
    logic [4:0] bad_op;
    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.operation   <= '0;
    in_bus.reg_first   <= '0;
    in_bus.reg_second  <= '0;
    in_bus.immediate   <= '0;
    in_bus.jump_target <= '0;
    in_bus.memory_data <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_code_size(32'd4096);

    // Directed: empty-stack no-ops, field extremes, add, shift, not, negate,
    // scramble, unscramble and compare, bad register indices, load round trip, call and return.
    send_word(make_word(OP_POP, 8'd0));
    send_word(make_word(OP_RET));
    send_word(make_word(OP_ADD));
    send_word(make_word(OP_PUSH_CONST, 0, 0, '1));
    send_word(make_word(OP_PUSH_CONST, 0, 0, 64'h8000_0000_0000_0001));
    send_word(make_word(OP_ADD));
    send_word(make_word(OP_PUSH_CONST, 0, 0, 64'h7F));
    send_word(make_word(OP_SHL));
    send_word(make_word(OP_PUSH_CONST, 0, 0, 64'h41));
    send_word(make_word(OP_SHR));
    send_word(make_word(OP_NOT));
    send_word(make_word(OP_NEG));
    send_word(make_word(OP_PUSH_CONST, 0, 0, 64'h0123_4567_89AB_CDEF));
    send_word(make_word(OP_SCRAMBLE));
    send_word(make_word(OP_PUSH_CONST, 0, 0, 64'h0123_4567_89AB_CDEF));
    send_word(make_word(OP_UNSCRAMBLE));
    send_word(make_word(OP_PUSH_GPR, 8'd15));
    send_word(make_word(OP_CMP));
    send_word(make_word(OP_POP, 8'd15));
    send_word(make_word(OP_PUSH_GPR, 8'd200));
    send_word(make_word(OP_MOV, 8'd3, 8'd15));
    send_word(make_word(OP_MOV, 8'd16, 8'd255));
    send_word(make_word(OP_PUSH_CONST, 0, 0, 64'h40));
    send_word(make_word(OP_LOAD, 8'd5));
    send_word(make_word(OP_LOAD_DATA));
    send_word(make_word(OP_LOAD_DATA));
    send_word(make_word(OP_MEM_WRITE, 8'd255));
    send_word(make_word(OP_CALL, 0, 0, 0, 32'h300));
    send_word(make_word(OP_RET));
    send_word(make_word(OP_NOP));

    // Widest code: let the pc wrap past the top of its range.
    write_code_size(32'hFFFF_FFFF);
    send_word(make_word(OP_JMP, 0, 0, 0, 32'hFFFF_FFF9));
    send_word(make_word(OP_PUSH_CONST, 0, 0, {$urandom, $urandom}));

    // Fill the stack past full, then work it down.
    send_idle_pct = 17;
    take_idle_pct = 17;
    run_random(280, 90);
    run_random(200, 20);

    write_code_size(32'd16);
    run_random(150, 35);

    // Stretch with no idling on either side.
    send_idle_pct = 0;
    take_idle_pct = 0;
    write_code_size(32'h0001_0000);
    run_random(250, 35);

    send_idle_pct = 17;
    take_idle_pct = 17;
    write_code_size($urandom_range(64, 32'hFFFF_FFFF));
    run_random(480, 35);

    // Leave a load pending, then stop the machine one of four ways.
    send_word(make_word(OP_JMP, 0, 0, 0, 32'd0));
    send_word(make_word(OP_PUSH_CONST, 0, 0, {$urandom, $urandom}));
    send_word(make_word(OP_LOAD, 8'($urandom_range(0, REGS_N - 1))));
    case ($urandom_range(0, 3))
      0: send_word(make_word(OP_HALT));
      1: begin
        do bad_op = 5'($urandom_range(OP_UNKNOWN, 31));
        while (bad_op == OP_LOAD_DATA);
        send_word(make_word(bad_op));
      end
      2: begin
        write_code_size($urandom_range(0, sb.machine.pc), 1'b0);
        send_word(make_word(OP_NOP));
      end
      default: while (sb.machine.running) send_word(random_word(35));
    endcase

    // A stopped machine only answers load data.
    repeat (20) begin
      send_word(make_word(5'($urandom_range(0, 31)), 8'($urandom), 8'($urandom),
                          {$urandom, $urandom}, $urandom));
    end

    drain();
    if (sb.fails == 0 && sb.results_due.size() == 0) begin
      $display("tb_stack_vm_execute OK");
    end else begin
      $display("tb_stack_vm_execute NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/svm_pkg.sv
rtl/core/svm_if.sv
rtl/core/svm_stack_mem.sv
rtl/core/svm_reg_file.sv
rtl/core/svm_alu_seq.sv
rtl/core/stack_vm_execute.sv
tb/tb_stack_vm_execute.sv
